// File: design/battery_gauge_interpolator_assert.svh
// Assertion macros shared by the battery gauge checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BATTERY_GAUGE_INTERPOLATOR_ASSERT_SVH
`define BATTERY_GAUGE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BGI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgi assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define BGI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgi assertion failed");

`endif

// File: design/bgi_pkg.sv
// Shared types and constants of the battery gauge interpolator.
// No dependencies; imported by every module of the block except bgi_divider.
package bgi_pkg;

  // Port field widths
  localparam int SAMPLE_W   = 12;
  localparam int MV_W       = 14;
  localparam int PCT_W      = 7;
  localparam int RATIO_W    = 3;
  localparam int HYST_W     = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 7;

  // Parameter defaults
  localparam int SAMPLES_DEF     = 8;
  localparam int SAMPLE_BITS_DEF = 12;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DIVIDER_RATIO = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_PERCENT_HYST  = 1'b1;

  // Register reset values
  localparam logic [RATIO_W-1:0] RATIO_RESET = 3'd2;
  localparam logic [HYST_W-1:0]  HYST_RESET  = 7'd1;

  // Cell curve: millivolts and percent at each knee
  localparam int CURVE_POINTS = 8;
  localparam int SEG_W        = $clog2(CURVE_POINTS);
  localparam int CURVE_MV_W   = 13;
  localparam int SPAN_BASE_W  = 8;   // widest gap between knees is 200 mV
  localparam int DP_W         = 5;   // widest percent step is 20
  localparam logic [CURVE_MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    13'd3200, 13'd3300, 13'd3500, 13'd3700, 13'd3850, 13'd4000, 13'd4100, 13'd4200
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd0, 7'd5, 7'd20, 7'd40, 7'd60, 7'd80, 7'd90, 7'd100
  };

  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [MV_W-1:0]  MV_MAX    = 14'd16383;

  // Controller to datapath
  typedef struct packed {
    logic acc;        // accumulate the input beat
    logic scale;      // sum times divider ratio
    logic seg;        // locate the curve segment
    logic diff;       // offset into segment, span, step
    logic mult;       // interpolation numerator
    logic div_start;  // launch the interpolation divide
    logic mv_load;    // capture averaged voltage
    logic fin_load;   // load result register, update hysteresis
  } bgi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_sample;
    logic div_idle;
    logic out_free;
  } bgi_status_t;

endpackage

// File: design/bgi_divider.sv
// Restoring divider producing a DIV_W-bit quotient, one quotient bit per cycle.
// Depends on nothing outside itself; used by bgi_datapath.
module bgi_divider #(
  parameter int DIV_W = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic             idle_o,
  output logic [DIV_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] nq_q, nq_d;   // dividend shifts out, quotient shifts in
  logic [DIV_W-1:0] den_q, den_d;
  logic [DIV_W:0]   trial;

  // One trial subtraction per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    nq_d   = nq_q;
    den_d  = den_q;
    trial  = {rem_q, nq_q[DIV_W-1]} - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      nq_d   = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial[DIV_W]) begin
        rem_d = {rem_q[DIV_W-2:0], nq_q[DIV_W-1]};
        nq_d  = {nq_q[DIV_W-2:0], 1'b0};
      end else begin
        rem_d = trial[DIV_W-1:0];
        nq_d  = {nq_q[DIV_W-2:0], 1'b1};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    den_q <= den_d;
  end

  assign idle_o = !busy_q;
  assign quo_o  = nq_q;

endmodule

// File: design/bgi_datapath.sv
// Datapath: sample accumulator, config registers, segment lookup,
// interpolation numerator, serial divider, hysteresis and result register.
// Depends on bgi_pkg and bgi_divider.
module bgi_datapath
  import bgi_pkg::*;
#(
  parameter int SAMPLES     = SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bgi_cmd_t              cmd_i,
  output bgi_status_t           status_o,
  input  logic [SAMPLE_W-1:0]   sample_mv_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [MV_W-1:0]       battery_mv_o,
  output logic [PCT_W-1:0]      measured_percent_o,
  output logic [PCT_W-1:0]      reported_percent_o,
  output logic                  report_changed_o
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(SAMPLES);
  localparam int IDX_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SCL_W  = SUM_W + RATIO_W;
  localparam int CRV_W  = CURVE_MV_W + $clog2(SAMPLES);
  localparam int CMP_W  = (SCL_W > CRV_W) ? SCL_W : CRV_W;
  localparam int SPAN_W = SPAN_BASE_W + $clog2(SAMPLES);
  localparam int NUM_W  = SPAN_W + DP_W + 1;
  localparam int DIV_W  = NUM_W;

  // Averaging by reciprocal multiplication, exact over the scaled range
  localparam int MVF_W  = (SCL_W > MV_W) ? SCL_W : MV_W;
  localparam int RCP_SH = SCL_W + $clog2(SAMPLES);
  localparam int RCP_W  = SCL_W + 1;
  localparam int PROD_W = SCL_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((longint'(1) << RCP_SH) + longint'(SAMPLES) - 1) / longint'(SAMPLES));

  // Config registers
  logic [RATIO_W-1:0] ratio_q;
  logic [HYST_W-1:0]  hyst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RATIO_RESET;
      hyst_q  <= HYST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DIVIDER_RATIO: ratio_q <= cfg_data_i[RATIO_W-1:0];
        REG_PERCENT_HYST:  hyst_q  <= cfg_data_i[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample accumulation
  logic [SAMPLE_BITS-1:0] smp;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   last_sample;

  assign smp         = SAMPLE_BITS'(sample_mv_i);
  assign last_sample = (idx_q == IDX_W'(SAMPLES - 1));

  always_comb begin
    sum_d = sum_q;
    idx_d = idx_q;
    if (cmd_i.acc) begin
      sum_d = sum_q + SUM_W'(smp);
      idx_d = last_sample ? '0 : idx_q + IDX_W'(1);
    end else if (cmd_i.scale) begin
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      idx_q <= '0;
    end else begin
      sum_q <= sum_d;
      idx_q <= idx_d;
    end
  end

  // Curve knees scaled by the group size
  logic [CMP_W-1:0] pt [CURVE_POINTS];
  always_comb begin
    for (int k = 0; k < CURVE_POINTS; k++) begin
      pt[k] = CMP_W'(CURVE_MV[k]) * CMP_W'(SAMPLES);
    end
  end

  // Scale, segment search, segment offset, numerator
  logic [SCL_W-1:0]  scaled_q;
  logic [CMP_W-1:0]  scaled_cmp;
  logic [SEG_W-1:0]  seg_d, seg_q, seg_lo;
  logic              below_q, above_q;
  logic [SPAN_W-1:0] diff_q, span_q;
  logic [DP_W-1:0]   dp_q;
  logic [PCT_W-1:0]  base_q;
  logic [NUM_W-1:0]  num_q;

  assign scaled_cmp = CMP_W'(scaled_q);
  assign seg_lo     = seg_q - SEG_W'(1);

  // First knee at or above the voltage
  always_comb begin
    seg_d = SEG_W'(CURVE_POINTS - 1);
    for (int k = CURVE_POINTS - 1; k >= 1; k--) begin
      if (scaled_cmp <= pt[k]) begin
        seg_d = SEG_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      scaled_q <= SCL_W'(sum_q) * SCL_W'(ratio_q);
    end
    if (cmd_i.seg) begin
      seg_q   <= seg_d;
      below_q <= (scaled_cmp <= pt[0]);
      above_q <= (scaled_cmp > pt[CURVE_POINTS-1]);
    end
    if (cmd_i.diff) begin
      diff_q <= SPAN_W'(scaled_cmp - pt[seg_lo]);
      span_q <= SPAN_W'(pt[seg_q] - pt[seg_lo]);
      dp_q   <= DP_W'(CURVE_PCT[seg_q] - CURVE_PCT[seg_lo]);
      base_q <= CURVE_PCT[seg_lo];
    end
    if (cmd_i.mult) begin
      num_q <= {(NUM_W-1)'(diff_q) * (NUM_W-1)'(dp_q), 1'b0} + NUM_W'(span_q);
    end
  end

  // Interpolation divide: numerator over twice the span
  logic [DIV_W-1:0] div_num, div_den, quo;
  logic             div_idle;

  assign div_num = num_q;
  assign div_den = DIV_W'({span_q, 1'b0});

  bgi_divider #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .idle_o  (div_idle),
    .quo_o   (quo)
  );

  // Saturated voltage
  logic [PROD_W-1:0] mv_prod;
  logic [MVF_W-1:0]  mv_full;
  logic [MV_W-1:0]   mv_q;

  assign mv_prod = PROD_W'(scaled_q) * PROD_W'(RCP);
  assign mv_full = MVF_W'(mv_prod >> RCP_SH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mv_load) begin
      mv_q <= (mv_full > MVF_W'(MV_MAX)) ? MV_MAX : mv_full[MV_W-1:0];
    end
  end

  // Percent and hysteresis
  logic [PCT_W-1:0] meas, held_q, adiff;
  logic             held_valid_q, changed;

  always_comb begin
    if (below_q) begin
      meas = PCT_EMPTY;
    end else if (above_q) begin
      meas = PCT_FULL;
    end else begin
      meas = base_q + quo[PCT_W-1:0];
    end
    adiff   = (meas > held_q) ? meas - held_q : held_q - meas;
    changed = !held_valid_q || (adiff > hyst_q);
  end

  // Result register
  logic out_valid_q;
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
    end else begin
      if (cmd_i.fin_load) begin
        out_valid_q <= 1'b1;
        if (changed) begin
          held_q       <= meas;
          held_valid_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_load) begin
      battery_mv_o       <= mv_q;
      measured_percent_o <= meas;
      reported_percent_o <= changed ? meas : held_q;
      report_changed_o   <= changed;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o.last_sample = last_sample;
  assign status_o.div_idle    = div_idle;
  assign status_o.out_free    = out_free;

endmodule

// File: design/bgi_ctrl.sv
// Controller: sequences accumulation, segment lookup, the interpolation
// divide and result hand-off. Depends on bgi_pkg.
module bgi_ctrl
  import bgi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  bgi_status_t status_i,
  output bgi_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_ACC     = 8'b0000_0001,
    ST_SCALE   = 8'b0000_0010,
    ST_SEG     = 8'b0000_0100,
    ST_DIFF    = 8'b0000_1000,
    ST_MULT    = 8'b0001_0000,
    ST_DIV_GO  = 8'b0010_0000,
    ST_DIV_PCT = 8'b0100_0000,
    ST_FIN     = 8'b1000_0000
  } bgi_state_e;

  bgi_state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_ACC: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (status_i.last_sample) begin
            state_d = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_SEG;
      end
      ST_SEG: begin
        cmd_o.seg = 1'b1;
        state_d   = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mult    = 1'b1;
        cmd_o.mv_load = 1'b1;
        state_d       = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_PCT;
      end
      ST_DIV_PCT: begin
        if (status_i.div_idle) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.fin_load = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/battery_gauge_interpolator.sv
// Inside a group, one sample beat is taken every cycle. After the last beat the
// result passes four setup states (scale, segment, offset, numerator), the divide
// launch, the one-bit-per-cycle divide (DIV_W = 17 by default) and the hand-off.
// Input stalls meanwhile, so a new group starts only after that hand-off. A waiting
// result does not block the next group's samples, only that group's hand-off.
// Async active-low reset clears sum, count, held percent, output valid; ratio 2, hyst 1.
module battery_gauge_interpolator
  import bgi_pkg::*;
#(
  parameter int SAMPLES     = SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SAMPLE_W-1:0]   sample_mv_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [MV_W-1:0]       battery_mv_o,
  output logic [PCT_W-1:0]      measured_percent_o,
  output logic [PCT_W-1:0]      reported_percent_o,
  output logic                  report_changed_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  bgi_cmd_t    cmd;
  bgi_status_t status;

  bgi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bgi_datapath #(
    .SAMPLES     (SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .sample_mv_i        (sample_mv_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_data_i         (cfg_data_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .battery_mv_o       (battery_mv_o),
    .measured_percent_o (measured_percent_o),
    .reported_percent_o (reported_percent_o),
    .report_changed_o   (report_changed_o)
  );

endmodule

// File: design/bgi_checker.sv
// Port-level checks of the battery gauge result channel, bound to the top.
// Depends on bgi_pkg and battery_gauge_interpolator_assert.svh.
`include "battery_gauge_interpolator_assert.svh"

module bgi_checker
  import bgi_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [MV_W-1:0]  battery_mv_o,
  input logic [PCT_W-1:0] measured_percent_o,
  input logic [PCT_W-1:0] reported_percent_o,
  input logic             report_changed_o
);

  // A stalled result beat stays offered
  `BGI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Percentages stay within the scale
  `BGI_ASSERT_NOW(a_pct_range, clk_i, rst_ni, out_valid_o, (measured_percent_o <= PCT_FULL) && (reported_percent_o <= PCT_FULL))

  // A taken measurement is what gets reported
  `BGI_ASSERT_NOW(a_report_follows, clk_i, rst_ni, out_valid_o && report_changed_o, reported_percent_o == measured_percent_o)

  // Below the empty knee reads empty
  `BGI_ASSERT_NOW(a_empty, clk_i, rst_ni, out_valid_o && (battery_mv_o < MV_W'(CURVE_MV[0])), measured_percent_o == PCT_EMPTY)

  // At or above the full knee reads full
  `BGI_ASSERT_NOW(a_full, clk_i, rst_ni, out_valid_o && (battery_mv_o >= MV_W'(CURVE_MV[CURVE_POINTS-1])), measured_percent_o == PCT_FULL)

endmodule

bind battery_gauge_interpolator bgi_checker u_bgi_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .battery_mv_o       (battery_mv_o),
  .measured_percent_o (measured_percent_o),
  .reported_percent_o (reported_percent_o),
  .report_changed_o   (report_changed_o)
);
